// File: rtl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and codes for the key/value table: request and response
// payloads, request kinds, status codes and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kvt_pkg;

	// Width of the key, value and read_value fields on the ports.
	localparam int WORD_W = 64;

	// Request kinds.
	localparam logic [1:0] REQ_PUT    = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// Response status codes.
	localparam logic [2:0] STAT_UPDATED  = 3'd0;
	localparam logic [2:0] STAT_INSERTED = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_FOUND    = 3'd3;
	localparam logic [2:0] STAT_MISSING  = 3'd4;
	localparam logic [2:0] STAT_DELETED  = 3'd5;

	// Request payload.
	typedef struct packed {
		logic [1:0]        req_type;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] value;
	} kvt_req_t;

	// Response payload.
	typedef struct packed {
		logic [2:0]        status;
		logic [WORD_W-1:0] read_value;
	} kvt_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // capture a request and restart the scan
		logic clr_step;  // clear one table slot
		logic scan_step; // issue the next slot read
		logic finish;    // commit the table write and load the response
	} kvt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;  // the slot being cleared is the last one
		logic scan_done; // a match was found or every slot was compared
	} kvt_sts_t;

endpackage

// File: rtl/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Controller state machine of the key/value table. It runs the clearing pass
// after reset, accepts one request at a time, steps the slot scan and hands
// the finished response to the output register.
// ----------------------------------------------------------------------------
module kvt_ctrl
	import kvt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output kvt_cmd_t cmd,
	input  kvt_sts_t sts
);

	typedef enum logic [1:0] {
		CLEAR,
		IDLE,
		SCAN,
		FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	// The output register can take a new response when it is empty or being drained.
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Commands follow from the state, gated by req_valid and by a free output register.
	always_comb begin
		cmd           = '0;
		cmd.start     = (state_q == IDLE) && req_valid;
		cmd.clr_step  = (state_q == CLEAR);
		cmd.scan_step = (state_q == SCAN);
		cmd.finish    = (state_q == FINISH) && out_free;
	end

	assign req_stall = (state_q != IDLE);
	assign rsp_valid = rsp_valid_q;

	// State and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new response is loaded in the same cycle that the old one drains.
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					if (sts.clr_last) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (req_valid) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (sts.scan_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath
// Datapath of the key/value table: the slot memory, the request register,
// the one-slot-per-cycle scan with its match and free-slot trackers, and the
// response register.
// ----------------------------------------------------------------------------
module kvt_datapath
	import kvt_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  kvt_req_t req,
	output kvt_rsp_t rsp,
	input  kvt_cmd_t cmd,
	output kvt_sts_t sts
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic                  vld;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] val;
	} entry_t;

	entry_t mem [ENTRIES];

	// Captured request.
	logic [1:0]            kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// Scan control.
	logic [IDX_W-1:0] idx_q;
	logic             issued_q;
	logic             rd_en;
	entry_t           rd_data_s1;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             done_q;

	// Match and free-slot trackers.
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	// Finish-time write and response.
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             fin_wr;
	logic [IDX_W-1:0] fin_addr;
	entry_t           fin_data;
	kvt_rsp_t         fin_rsp;
	kvt_rsp_t         rsp_q;

	assign rd_en = cmd.scan_step && !issued_q;

	// Request capture, masked to the configured key and value widths.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= req.req_type;
			key_q  <= req.key[KEY_BITS-1:0];
			val_q  <= req.value[VALUE_BITS-1:0];
		end
	end

	// Slot counter, shared by the clearing pass and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			issued_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			// No read is issued in the cycle that starts a request.
			rd_vld_s1 <= rd_en;
			if (cmd.start) begin
				idx_q     <= '0;
				issued_q  <= 1'b0;
				done_q    <= 1'b0;
			end else if (cmd.clr_step) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end else if (rd_en) begin
				if (idx_q == LAST_IDX) begin
					issued_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (!cmd.start && rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
				done_q <= 1'b1;
			end
		end
	end

	// Registered memory read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q];
			rd_idx_s1  <= idx_q;
		end
	end

	// Compare stage: keep the lowest matching slot and the lowest free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_data_s1.vld && (rd_data_s1.key == key_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!rd_data_s1.vld && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !cmd.start) begin
			if (rd_data_s1.vld && (rd_data_s1.key == key_q) && !hit_q) begin
				hit_idx_q <= rd_idx_s1;
				hit_val_q <= rd_data_s1.val;
			end
			if (!rd_data_s1.vld && !free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	// Outcome of the request: table write and response.
	always_comb begin
		fin_wr             = 1'b0;
		fin_addr           = hit_idx_q;
		fin_data.vld       = 1'b1;
		fin_data.key       = key_q;
		fin_data.val       = val_q;
		fin_rsp.status     = STAT_MISSING;
		fin_rsp.read_value = '0;
		case (kind_q)
			REQ_PUT: begin
				if (hit_q) begin
					fin_wr         = 1'b1;
					fin_rsp.status = STAT_UPDATED;
				end else if (free_q) begin
					fin_wr         = 1'b1;
					fin_addr       = free_idx_q;
					fin_rsp.status = STAT_INSERTED;
				end else begin
					fin_rsp.status = STAT_FULL;
				end
			end
			REQ_GET: begin
				if (hit_q) begin
					fin_rsp.status     = STAT_FOUND;
					fin_rsp.read_value = WORD_W'(hit_val_q);
				end
			end
			REQ_DELETE: begin
				if (hit_q) begin
					fin_wr         = 1'b1;
					fin_data.vld   = 1'b0;
					fin_rsp.status = STAT_DELETED;
				end
			end
			default: begin
				fin_rsp.status = STAT_MISSING;
			end
		endcase
	end

	// Single write port: the clearing pass or the finish-time update.
	always_comb begin
		wr_en   = cmd.clr_step || (cmd.finish && fin_wr);
		wr_addr = cmd.clr_step ? idx_q : fin_addr;
		wr_data = cmd.clr_step ? entry_t'('0) : fin_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= fin_rsp;
		end
	end

	assign rsp           = rsp_q;
	assign sts.clr_last  = (idx_q == LAST_IDX);
	assign sts.scan_done = hit_q || done_q;

endmodule

// File: rtl/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// Fixed table of key/value slots serving put, get and delete requests.
// ----------------------------------------------------------------------------
// The table holds ENTRIES slots in a memory with one read port and one write
// port that is scanned one slot per cycle from slot 0 upward; a request uses
// the lowest valid slot whose key matches, and a put without a match fills
// the lowest free slot. One request is served at a time: the scan stops at
// the first matching slot, so a hit in a low slot frees the table sooner
// than a miss, which reads every slot through the memory read port. Each
// request gives exactly one response, held in an output register so that a
// new request is accepted while a response waits. After reset the table runs
// a clearing pass over every slot, during which req_stall stays high.
// ----------------------------------------------------------------------------
module key_value_table
	import kvt_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  kvt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output kvt_rsp_t rsp
);

	kvt_cmd_t cmd;
	kvt_sts_t sts;

	// Sequencing of the clearing pass, scan and response.
	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Slot memory, compare logic and response register.
	kvt_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// File: tb/key_value_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_tb
// Self-checking testbench for the key/value table. A scoreboard keeps its own
// copy of the slots, predicts the status and read value of every accepted
// request, and compares each response transfer against the oldest prediction.
// Stimulus starts with a directed sequence (extreme keys and values, every
// request kind, update, delete, reuse of a freed slot, full table) and goes on
// with random requests over a small key pool so that hits, misses and a full
// table all occur often. Idle and stall rates change from phase to phase, and
// the receiver once holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module key_value_table_tb;
	import kvt_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;

	// Request kind that the block does not define; it must answer key missing.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 6;
	localparam int PHASES           = 4;
	localparam int RANDOM_PER_PHASE = 450;
	localparam int POOL_SIZE        = 24;
	localparam int HOLD_AT          = 60;
	localparam int HOLD_CYCLES      = 300;
	localparam int DRAIN_CYCLES     = 4 * (ENTRIES + 5);
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int MAX_REPORTS      = 10;

	// Idle percentages of the sender and the receiver, one pair per phase.
	localparam int SENDER_IDLE[PHASES]    = '{0, 70, 0, 15};
	localparam int RECEIVER_STALL[PHASES] = '{0, 0, 70, 15};

	typedef logic [KEY_BITS-1:0]   key_word_t;
	typedef logic [VALUE_BITS-1:0] value_word_t;

	// Tracks the slot contents and the responses still owed by the block.
	class kv_table_scoreboard;
		bit          slot_valid[ENTRIES];
		key_word_t   slot_key[ENTRIES];
		value_word_t slot_value[ENTRIES];
		kvt_rsp_t    expected_rsp[$];
		int          failures;

		function new();
			foreach (slot_valid[i])
				slot_valid[i] = 1'b0;
			failures = 0;
		endfunction

		// Apply one accepted request to the slots and queue its response.
		function void note_request(kvt_req_t r);
			key_word_t   k;
			value_word_t v;
			kvt_rsp_t    want;
			int          hit;
			int          spare;
			k = r.key[KEY_BITS-1:0];
			v = r.value[VALUE_BITS-1:0];
			hit = -1;
			spare = -1;
			// Scan downward so that the lowest matching and free slots win.
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (slot_valid[i] && slot_key[i] == k)
					hit = i;
				if (!slot_valid[i])
					spare = i;
			end
			want.status = STAT_MISSING;
			want.read_value = '0;
			case (r.req_type)
				REQ_PUT: begin
					if (hit >= 0) begin
						slot_value[hit] = v;
						want.status = STAT_UPDATED;
					end else if (spare >= 0) begin
						slot_valid[spare] = 1'b1;
						slot_key[spare] = k;
						slot_value[spare] = v;
						want.status = STAT_INSERTED;
					end else begin
						want.status = STAT_FULL;
					end
				end
				REQ_GET: begin
					if (hit >= 0) begin
						want.read_value[VALUE_BITS-1:0] = slot_value[hit];
						want.status = STAT_FOUND;
					end
				end
				REQ_DELETE: begin
					if (hit >= 0) begin
						slot_valid[hit] = 1'b0;
						want.status = STAT_DELETED;
					end
				end
				default: begin
				end
			endcase
			expected_rsp.push_back(want);
		endfunction

		// Compare one response transfer against the oldest prediction.
		function void check_response(kvt_rsp_t got);
			kvt_rsp_t want;
			if (expected_rsp.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: response with none outstanding: status %0d value %h",
						$time, got.status, got.read_value);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status || got.read_value !== want.read_value) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display({"%0t: mismatch: expected status %0d value %h, ",
						"got status %0d value %h"},
						$time, want.status, want.read_value, got.status, got.read_value);
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	kvt_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	kvt_rsp_t rsp;

	int        sender_idle_pct = 0;
	int        receiver_stall_pct = 0;
	int        requests_accepted = 0;
	int        quiet_cycles = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	key_word_t key_pool[POOL_SIZE];

	kv_table_scoreboard scoreboard;

	key_value_table #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Offer one request after a random idle gap and wait for its transfer.
	task automatic send_request(input logic [1:0] kind, input key_word_t k,
			input value_word_t v);
		kvt_req_t r;
		r = '0;
		r.req_type = kind;
		r.key[KEY_BITS-1:0] = k;
		r.value[VALUE_BITS-1:0] = v;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Mostly pool keys, some with one bit flipped, some fully random.
	task automatic send_random_request();
		logic [1:0] kind;
		key_word_t  k;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 40)
			kind = REQ_PUT;
		else if (pick < 70)
			kind = REQ_GET;
		else if (pick < 95)
			kind = REQ_DELETE;
		else
			kind = REQ_UNUSED;
		k = key_pool[$urandom_range(POOL_SIZE - 1)];
		pick = $urandom_range(99);
		if (pick >= 92)
			k = random_word();
		else if (pick >= 85)
			k[$urandom_range(KEY_BITS - 1)] ^= 1'b1;
		send_request(kind, k, random_word());
	endtask

	// Observe both channels and feed every transfer to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				scoreboard.note_request(req);
				requests_accepted <= requests_accepted + 1;
			end
			if (rsp_valid && !rsp_stall)
				scoreboard.check_response(rsp);
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs up the block.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && requests_accepted >= HOLD_AT) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		scoreboard = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = random_word();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme keys and values, update, delete, misses, unused kind.
		send_request(REQ_PUT, key_pool[0], '0);
		send_request(REQ_PUT, key_pool[1], '1);
		send_request(REQ_GET, key_pool[0], '1);
		send_request(REQ_GET, key_pool[1], '0);
		send_request(REQ_PUT, key_pool[0], {32{2'b01}});
		send_request(REQ_DELETE, key_pool[0], '0);
		send_request(REQ_GET, key_pool[0], '0);
		send_request(REQ_DELETE, key_pool[0], '0);
		send_request(REQ_UNUSED, key_pool[1], '1);
		// The freed lowest slot is reused, then the table is filled up.
		send_request(REQ_PUT, key_pool[0], {32{2'b10}});
		for (int i = 2; i < ENTRIES; i++)
			send_request(REQ_PUT, key_pool[i], random_word());
		send_request(REQ_PUT, key_pool[ENTRIES], random_word());
		send_request(REQ_GET, key_pool[ENTRIES - 1], '0);

		// Random requests under changing idle and stall rates.
		for (int phase = 0; phase < PHASES; phase++) begin
			sender_idle_pct = SENDER_IDLE[phase];
			receiver_stall_pct <= RECEIVER_STALL[phase];
			repeat (RANDOM_PER_PHASE)
				send_random_request();
		end
		req_valid <= 1'b0;

		// Wait for every owed response, then watch for strays.
		while (scoreboard.expected_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (scoreboard.failures == 0 && scoreboard.expected_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/kvt_pkg.sv
rtl/kvt_ctrl.sv
rtl/kvt_datapath.sv
rtl/key_value_table.sv
tb/key_value_table_tb.sv
